[sv/sapq_pkg.sv]
// ----------------------------------------------------------------------------
// sapq_pkg: shared types for the sorted-array priority queue
// Operation and status codes, controller states and the command/status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sapq_pkg;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ_CHK,
      ST_ENQ_CMP,
      ST_DEQ,
      ST_DEQ_LOAD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       latch;       // capture request, arm insert cursor
      logic       clear;       // drop all entries
      logic       rd_prev;     // read the entry in front of the cursor
      logic       wr_old;      // move read entry back one slot, step cursor
      logic       wr_new;      // place new entry at cursor
      logic       deq;         // pop head
      logic       load_head;   // refresh head registers from read data
      logic       set_status;
      status_type status_code;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic cursor_zero;
      logic rd_greater;
      logic last_entry;
   } dp_status_type;

endpackage

[sv/sapq_ctrl.sv]
// ----------------------------------------------------------------------------
// sapq_ctrl: sequencer for the sorted-array priority queue
// Decodes each accepted beat and steps the datapath through insert shifts,
// head pops and the single-cycle result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sapq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_op,
   input  sapq_pkg::dp_status_type dp_status,
   output sapq_pkg::cmd_type      cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);
   import sapq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.latch = 1'b1;
               case (op_type'(req_op))
                  OP_ENQUEUE: begin
                     if (dp_status.full) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STAT_FULL;
                        state_in        = ST_RESP;
                     end else begin
                        state_in = ST_ENQ_CHK;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (dp_status.empty) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STAT_EMPTY;
                        state_in        = ST_RESP;
                     end else begin
                        state_in = ST_DEQ;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_ENQ_CHK: begin
            if (dp_status.cursor_zero) begin
               cmd.wr_new = 1'b1;
               state_in   = ST_RESP;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = ST_ENQ_CMP;
            end
         end
         ST_ENQ_CMP: begin
            // shift the larger entry back, else drop the new one in here
            if (dp_status.rd_greater) begin
               cmd.wr_old = 1'b1;
               state_in   = ST_ENQ_CHK;
            end else begin
               cmd.wr_new = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_DEQ: begin
            cmd.deq = 1'b1;
            if (dp_status.last_entry) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_DEQ_LOAD;
            end
         end
         ST_DEQ_LOAD: begin
            cmd.load_head = 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/sapq_dp.sv]
// ----------------------------------------------------------------------------
// sapq_dp: datapath for the sorted-array priority queue
// Entries sit in a circular memory in priority order starting at the head
// pointer; head tag and priority are mirrored in registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sapq_dp #(
   parameter int DEPTH    = 64,
   parameter int TAG_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sapq_pkg::cmd_type       cmd,
   input  logic [31:0]             req_value_tag,
   input  logic signed [31:0]      req_priority_req,
   output sapq_pkg::dp_status_type dp_status,
   output logic [31:0]             rsp_removed_tag,
   output logic [31:0]             rsp_head_tag,
   output logic signed [31:0]      rsp_head_priority,
   output logic                    rsp_head_valid,
   output logic [6:0]              rsp_entry_count,
   output logic [1:0]              rsp_status
);
   import sapq_pkg::*;

   localparam int AW      = $clog2(DEPTH);
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int ENTRY_W = TAG_BITS + 32;
   localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [ENTRY_W-1:0] mem [DEPTH];

   logic [CW-1:0]         count_ff;
   logic [AW-1:0]         head_ptr_ff;
   logic [AW-1:0]         cursor_ff;
   logic [TAG_BITS-1:0]   tag_req_ff;
   logic signed [31:0]    prio_req_ff;
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic [TAG_BITS-1:0]   head_tag_ff;
   logic signed [31:0]    head_prio_ff;
   logic [TAG_BITS-1:0]   removed_ff;
   status_type            status_ff;

   logic [TAG_BITS-1:0]   tag_in;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         next_head;
   logic                  rd_en;
   logic                  wr_en;
   logic [ENTRY_W-1:0]    wr_data;

   function automatic logic [AW-1:0] add_wrap(logic [AW-1:0] a, logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_A) begin
         s = s - DEPTH_A;
      end
      return s[AW-1:0];
   endfunction

   generate
      if (TAG_BITS <= 32) begin : g_tag_narrow
         assign tag_in = req_value_tag[TAG_BITS-1:0];
      end else begin : g_tag_wide
         assign tag_in = {{(TAG_BITS - 32){1'b0}}, req_value_tag};
      end
   endgenerate

   assign next_head = add_wrap(head_ptr_ff, AW'(1));
   assign wr_addr   = add_wrap(head_ptr_ff, cursor_ff);
   assign rd_addr   = cmd.deq ? next_head : add_wrap(head_ptr_ff, cursor_ff - AW'(1));
   assign rd_en     = cmd.deq | cmd.rd_prev;
   assign wr_en     = cmd.wr_old | cmd.wr_new;
   assign wr_data   = cmd.wr_new ? {tag_req_ff, prio_req_ff} : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         head_ptr_ff <= '0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (cmd.wr_new) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.deq) begin
            count_ff    <= count_ff - CW'(1);
            head_ptr_ff <= next_head;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         tag_req_ff  <= tag_in;
         prio_req_ff <= req_priority_req;
         cursor_ff   <= count_ff[AW-1:0];
         removed_ff  <= '0;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end else if (cmd.latch) begin
         status_ff <= STAT_OK;
      end
      if (cmd.wr_old) begin
         cursor_ff <= cursor_ff - AW'(1);
      end
      // a new entry at the front becomes the head
      if (cmd.wr_new && cursor_ff == '0) begin
         head_tag_ff  <= tag_req_ff;
         head_prio_ff <= prio_req_ff;
      end
      if (cmd.deq) begin
         removed_ff <= head_tag_ff;
      end
      if (cmd.load_head) begin
         head_tag_ff  <= rd_data_ff[ENTRY_W-1:32];
         head_prio_ff <= rd_data_ff[31:0];
      end
   end

   assign dp_status.empty       = (count_ff == '0);
   assign dp_status.full        = (count_ff == DEPTH_C);
   assign dp_status.cursor_zero = (cursor_ff == '0);
   assign dp_status.rd_greater  = ($signed(rd_data_ff[31:0]) > prio_req_ff);
   assign dp_status.last_entry  = (count_ff == CW'(1));

   assign rsp_head_valid    = (count_ff != '0);
   assign rsp_head_priority = rsp_head_valid ? head_prio_ff : '0;
   assign rsp_status        = status_ff;

   generate
      if (TAG_BITS <= 32) begin : g_out_narrow
         assign rsp_head_tag    = rsp_head_valid ? 32'(head_tag_ff) : '0;
         assign rsp_removed_tag = 32'(removed_ff);
      end else begin : g_out_wide
         assign rsp_head_tag    = rsp_head_valid ? head_tag_ff[31:0] : '0;
         assign rsp_removed_tag = removed_ff[31:0];
      end
      if (CW >= 7) begin : g_cnt_wide
         assign rsp_entry_count = count_ff[6:0];
      end else begin : g_cnt_narrow
         assign rsp_entry_count = {{(7 - CW){1'b0}}, count_ff};
      end
   endgenerate

endmodule

[sv/sorted_array_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_array_priority_queue: priority queue kept as a sorted array
// From start to rsp_strobe: clear, full/empty rejects and unused ops go
// straight to the strobe; dequeue pops the head and, unless it was the last
// entry, reloads the head registers; enqueue shifts larger entries back.
// busy drops the cycle after the strobe; one item is in work at a time.
// Reset empties the queue at once; entry memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_array_priority_queue #(
   parameter int DEPTH    = 64,
   parameter int TAG_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [31:0]        req_value_tag,
   input  logic signed [31:0] req_priority_req,
   output logic               rsp_strobe,
   output logic [31:0]        rsp_removed_tag,
   output logic [31:0]        rsp_head_tag,
   output logic signed [31:0] rsp_head_priority,
   output logic               rsp_head_valid,
   output logic [6:0]         rsp_entry_count,
   output logic [1:0]         rsp_status
);
   import sapq_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;

   sapq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_op),
      .dp_status  (dp_status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   sapq_dp #(
      .DEPTH    (DEPTH),
      .TAG_BITS (TAG_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_value_tag     (req_value_tag),
      .req_priority_req  (req_priority_req),
      .dp_status         (dp_status),
      .rsp_removed_tag   (rsp_removed_tag),
      .rsp_head_tag      (rsp_head_tag),
      .rsp_head_priority (rsp_head_priority),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_status        (rsp_status)
   );

endmodule
